[rtl/hmbc_pkg.sv]
package hmbc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned ModeW = 4;
  localparam int unsigned RoleW = 3;

  // Scanner mode codes.
  localparam logic [ModeW-1:0] MODE_TEXT   = 4'd0;
  localparam logic [ModeW-1:0] MODE_PFX1   = 4'd1;
  localparam logic [ModeW-1:0] MODE_PFX2   = 4'd2;
  localparam logic [ModeW-1:0] MODE_PFX3   = 4'd3;
  localparam logic [ModeW-1:0] MODE_TAG    = 4'd4;
  localparam logic [ModeW-1:0] MODE_TAGQ   = 4'd5;
  localparam logic [ModeW-1:0] MODE_CBODY  = 4'd6;
  localparam logic [ModeW-1:0] MODE_CDASH  = 4'd7;
  localparam logic [ModeW-1:0] MODE_CSPACE = 4'd8;

  // Byte role codes.
  localparam logic [RoleW-1:0] ROLE_TEXT     = 3'd0;
  localparam logic [RoleW-1:0] ROLE_OPEN     = 3'd1;
  localparam logic [RoleW-1:0] ROLE_TAG      = 3'd2;
  localparam logic [RoleW-1:0] ROLE_COMMENT  = 3'd3;
  localparam logic [RoleW-1:0] ROLE_TAGCLOSE = 3'd4;
  localparam logic [RoleW-1:0] ROLE_CMTCLOSE = 3'd5;

  localparam logic [ByteW-1:0] CH_LT    = 8'h3C;
  localparam logic [ByteW-1:0] CH_GT    = 8'h3E;
  localparam logic [ByteW-1:0] CH_BANG  = 8'h21;
  localparam logic [ByteW-1:0] CH_DASH  = 8'h2D;
  localparam logic [ByteW-1:0] CH_DQUOT = 8'h22;
  localparam logic [ByteW-1:0] CH_SQUOT = 8'h27;
  localparam logic [ByteW-1:0] CH_SPACE = 8'h20;
  localparam logic [ByteW-1:0] CH_TAB   = 8'h09;
  localparam logic [ByteW-1:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             quote_single;
  } scan_t;

  function automatic logic is_ws(input logic [ByteW-1:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

endpackage

[rtl/hmbc_step.sv]
module hmbc_step import hmbc_pkg::*; (
  input  scan_t             state_i,
  input  logic [ByteW-1:0]  byte_i,
  input  logic              doc_start_i,
  output scan_t             state_o,
  output logic [RoleW-1:0]  role_o
);

  scan_t cur;
  scan_t tag_state;
  logic [RoleW-1:0] tag_role;
  logic [ByteW-1:0] close_quote;

  // A new document drops whatever the previous one left open.
  always_comb begin
    cur = state_i;
    if (doc_start_i) begin
      cur.mode         = MODE_TEXT;
      cur.quote_single = 1'b0;
    end
  end

  // Tag rules for a byte outside quotes.
  always_comb begin
    tag_state = cur;
    tag_role  = ROLE_TAG;
    if (byte_i == CH_DQUOT || byte_i == CH_SQUOT) begin
      tag_state.mode         = MODE_TAGQ;
      tag_state.quote_single = (byte_i == CH_SQUOT);
    end else if (byte_i == CH_GT) begin
      tag_state.mode = MODE_TEXT;
      tag_role       = ROLE_TAGCLOSE;
    end else begin
      tag_state.mode = MODE_TAG;
    end
  end

  assign close_quote = cur.quote_single ? CH_SQUOT : CH_DQUOT;

  always_comb begin
    state_o = cur;
    role_o  = ROLE_TEXT;
    unique case (cur.mode)
      MODE_PFX1: begin
        if (byte_i == CH_BANG) begin
          state_o.mode = MODE_PFX2;
          role_o       = ROLE_TAG;
        end else begin
          state_o = tag_state;
          role_o  = tag_role;
        end
      end
      MODE_PFX2: begin
        if (byte_i == CH_DASH) begin
          state_o.mode = MODE_PFX3;
          role_o       = ROLE_TAG;
        end else begin
          state_o = tag_state;
          role_o  = tag_role;
        end
      end
      MODE_PFX3: begin
        if (byte_i == CH_DASH) begin
          state_o.mode = MODE_CBODY;
          role_o       = ROLE_COMMENT;
        end else begin
          state_o = tag_state;
          role_o  = tag_role;
        end
      end
      MODE_TAG: begin
        state_o = tag_state;
        role_o  = tag_role;
      end
      MODE_TAGQ: begin
        role_o = ROLE_TAG;
        if (byte_i == close_quote) begin
          state_o.mode = MODE_TAG;
        end
      end
      MODE_CBODY: begin
        role_o = ROLE_COMMENT;
        if (byte_i == CH_DASH) begin
          state_o.mode = MODE_CDASH;
        end
      end
      MODE_CDASH, MODE_CSPACE: begin
        role_o = ROLE_COMMENT;
        if (byte_i == CH_GT) begin
          state_o.mode = MODE_TEXT;
          role_o       = ROLE_CMTCLOSE;
        end else if (cur.mode == MODE_CDASH && byte_i == CH_DASH) begin
          state_o.mode = MODE_CDASH;
        end else if (is_ws(byte_i)) begin
          state_o.mode = MODE_CSPACE;
        end else begin
          // Anything else is swallowed and the dash search restarts.
          state_o.mode = MODE_CBODY;
        end
      end
      default: begin
        if (byte_i == CH_LT) begin
          state_o.mode = MODE_PFX1;
          role_o       = ROLE_OPEN;
        end else begin
          state_o.mode = MODE_TEXT;
          role_o       = ROLE_TEXT;
        end
      end
    endcase
  end

endmodule

[rtl/html_markup_byte_classifier.sv]
// A byte taken in is held in the input register and classified there; the byte and its role
// then move to the output register, which holds them until the output transfer.
// Throughput: one byte per cycle while m_axis_tready stays high. A result that waits
// holds both registers, and s_axis_tready falls once the input register is full.
// The scanner state update is a single small case per byte between the two registers.
// Reset (rst_ni low, asynchronous) empties both registers and puts the scanner in text mode.
module html_markup_byte_classifier import hmbc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [ByteW-1:0] s_axis_tdata,   // [7:0] byte_in
  input  logic             s_axis_tuser,   // [0] doc_start
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [ByteW-1:0] m_axis_tdata,   // [7:0] byte_out
  output logic [RoleW-1:0] m_axis_tuser    // [2:0] byte_role
);

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_start_q;
  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic [RoleW-1:0] out_role_q;
  scan_t            state_q;
  scan_t            state_d;
  logic [RoleW-1:0] role_d;
  logic             advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  hmbc_step u_step (
    .state_i     (state_q),
    .byte_i      (in_byte_q),
    .doc_start_i (in_start_q),
    .state_o     (state_d),
    .role_o      (role_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q           <= 1'b0;
      out_valid_q          <= 1'b0;
      state_q.mode         <= MODE_TEXT;
      state_q.quote_single <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
    if (advance) begin
      out_byte_q <= in_byte_q;
      out_role_q <= role_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_role_q;

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("output register not filled after a transfer moved forward");

  a_byte_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (m_axis_tdata == $past(in_byte_q)))
    else $error("output byte differs from the input byte");

  a_open_enters_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && role_d == ROLE_OPEN) |=> (state_q.mode == MODE_PFX1))
    else $error("tag opener did not start the comment prefix check");

  a_close_to_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (role_d == ROLE_TAGCLOSE || role_d == ROLE_CMTCLOSE))
      |=> (state_q.mode == MODE_TEXT))
    else $error("closing byte did not return the scanner to text");

endmodule
